// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is low
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, ignored while reset is low
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dtsg_pkg.sv =====
// ----------------------------------------------------------------------------
// dtsg_pkg
// types, register codes and sine table helpers for the dual-tone generator
// ----------------------------------------------------------------------------
`default_nettype none

package dtsg_pkg;

    localparam int STEP_W    = 25;
    localparam int CFG_IDX_W = 2;
    localparam int SAMPLE_W  = 15;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_STEP   = 2'd2;

    // pi in unsigned Q62
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // (a*b) >> sh, low 64 bits of the shifted full product
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int unsigned sh);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> sh;
        return prod[63:0];
    endfunction

    // taylor series of sin(x) in Q62, terms up to x^25, each product truncated
    function automatic logic [63:0] quarter_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_shift(x, x, 62);
        term = x;
        sum  = x;
        term = mul_shift(term, x2, 62) / 64'd6;   sum = sum - term;
        term = mul_shift(term, x2, 62) / 64'd20;  sum = sum + term;
        term = mul_shift(term, x2, 62) / 64'd42;  sum = sum - term;
        term = mul_shift(term, x2, 62) / 64'd72;  sum = sum + term;
        term = mul_shift(term, x2, 62) / 64'd110; sum = sum - term;
        term = mul_shift(term, x2, 62) / 64'd156; sum = sum + term;
        term = mul_shift(term, x2, 62) / 64'd210; sum = sum - term;
        term = mul_shift(term, x2, 62) / 64'd272; sum = sum + term;
        term = mul_shift(term, x2, 62) / 64'd342; sum = sum - term;
        term = mul_shift(term, x2, 62) / 64'd420; sum = sum + term;
        term = mul_shift(term, x2, 62) / 64'd506; sum = sum - term;
        term = mul_shift(term, x2, 62) / 64'd600; sum = sum + term;
        return sum;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dtsg_tone.sv =====
// ----------------------------------------------------------------------------
// dtsg_tone
// quarter-wave sine lookup mirrored over four quadrants, scaled per mode
// ----------------------------------------------------------------------------
`default_nettype none

module dtsg_tone #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic [$clog2(TABLE_DEPTH)+1:0] i_index,
    input  logic                           i_sample_mode,
    output dtsg_pkg::t_sample              o_level
);
    import dtsg_pkg::*;

    localparam int          ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [63:0] N4     = 64'(4 * TABLE_DEPTH);
    localparam logic [63:0] PiDiv  = PI_Q62 / N4;
    localparam logic [63:0] PiMod  = PI_Q62 % N4;

    logic [6:0]  w_lut8  [TABLE_DEPTH];
    logic [14:0] w_lut16 [TABLE_DEPTH];

    // table entry k holds sin((2k+1)*pi/(4*depth)) at both output scales
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] Odd   = 64'(2 * k + 1);
        localparam logic [63:0] Angle = PiDiv * Odd + (PiMod * Odd) / N4;
        localparam logic [63:0] Sin   = quarter_sin(Angle);
        localparam logic [63:0] P8    = mul_shift(64'd127, Sin, 62);
        localparam logic [63:0] P16   = mul_shift(64'd32766, Sin, 61) + 64'd1;
        assign w_lut8[k]  = P8[6:0];
        assign w_lut16[k] = P16[15:1];
    end

    logic [1:0]        w_quad;
    logic [ADDR_W-1:0] w_addr;
    logic [6:0]        w_t8;
    logic [14:0]       w_t16;
    logic [7:0]        w_off8;
    t_sample           w_mag16;

    always_comb begin
        w_quad  = i_index[ADDR_W+1:ADDR_W];
        // odd quadrants run the table backward
        w_addr  = w_quad[0] ? ~i_index[ADDR_W-1:0] : i_index[ADDR_W-1:0];
        w_t8    = w_lut8[w_addr];
        w_t16   = w_lut16[w_addr];
        w_off8  = w_quad[1] ? (8'd127 - {1'b0, w_t8}) : (8'd127 + {1'b0, w_t8});
        w_mag16 = t_sample'({2'b00, w_t16[14:2]});
        if (i_sample_mode) begin
            o_level = w_quad[1] ? -w_mag16 : w_mag16;
        end else begin
            o_level = t_sample'({8'd0, w_off8[7:1]});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dual_tone_sine_generator_top.sv =====
// ----------------------------------------------------------------------------
// dual_tone_sine_generator_top: two-tone dds sample source
// sample registered in the cycle after its request; one request per cycle sustained
// while the output is not stalled; one phase-add and table-read stage feeds the output register
// synchronous active-low reset clears phases, steps, mode and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module dual_tone_sine_generator_top #(
    parameter int TABLE_DEPTH         = 256,
    parameter int PHASE_FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dtsg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtsg_pkg::STEP_W-1:0]    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [0] restart
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // [14:0] tone_sample
    output logic                           m_axis_tlast
);
    import dtsg_pkg::*;

    // user keeps table depth a power of two (not enforced here); the period wrap is a truncation
    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int PHASE_W = ADDR_W + 2 + PHASE_FRACTION_BITS;
    localparam int SUM_W   = (PHASE_W > STEP_W) ? PHASE_W : STEP_W;

    logic               r_sample_mode;
    logic [STEP_W-1:0]  r_low_step;
    logic [STEP_W-1:0]  r_high_step;
    logic [PHASE_W-1:0] r_low_phase;
    logic [PHASE_W-1:0] r_high_phase;
    logic               r_out_valid;
    t_sample            r_out_sample;
    logic               r_out_last;

    logic [PHASE_W-1:0] n_low_phase;
    logic [PHASE_W-1:0] n_high_phase;
    logic [PHASE_W-1:0] w_low_cur;
    logic [PHASE_W-1:0] w_high_cur;
    logic [SUM_W-1:0]   w_low_sum;
    logic [SUM_W-1:0]   w_high_sum;
    t_sample            w_low_level;
    t_sample            w_high_level;
    t_sample            n_out_sample;
    logic               w_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_low_cur    = s_axis_tdata[0] ? '0 : r_low_phase;
        w_high_cur   = s_axis_tdata[0] ? '0 : r_high_phase;
        w_low_sum    = SUM_W'(w_low_cur) + SUM_W'(r_low_step);
        w_high_sum   = SUM_W'(w_high_cur) + SUM_W'(r_high_step);
        n_low_phase  = w_low_sum[PHASE_W-1:0];
        n_high_phase = w_high_sum[PHASE_W-1:0];
        n_out_sample = w_low_level + w_high_level;
    end

    dtsg_tone #(.TABLE_DEPTH(TABLE_DEPTH)) u_low_tone (
        .i_index       (w_low_cur[PHASE_W-1 -: ADDR_W+2]),
        .i_sample_mode (r_sample_mode),
        .o_level       (w_low_level)
    );

    dtsg_tone #(.TABLE_DEPTH(TABLE_DEPTH)) u_high_tone (
        .i_index       (w_high_cur[PHASE_W-1 -: ADDR_W+2]),
        .i_sample_mode (r_sample_mode),
        .o_level       (w_high_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_mode <= 1'b0;
            r_low_step    <= '0;
            r_high_step   <= '0;
            r_low_phase   <= '0;
            r_high_phase  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SAMPLE_MODE: r_sample_mode <= i_cfg_data[0];
                    CFG_LOW_STEP:    r_low_step    <= i_cfg_data;
                    CFG_HIGH_STEP:   r_high_step   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_low_phase  <= n_low_phase;
                r_high_phase <= n_high_phase;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_sample <= n_out_sample;
            r_out_last   <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_sample};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/dtsg_checker.sv =====
// ----------------------------------------------------------------------------
// dtsg_checker
// port-level checks on the dual-tone generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dtsg_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [dtsg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [dtsg_pkg::STEP_W-1:0]    i_cfg_data,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [7:0]                     s_axis_tdata,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [15:0]                    m_axis_tdata,
    input logic                           m_axis_tlast
);

    // a stalled sample holds
    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // output register empty right after reset
    `ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !m_axis_tvalid)

    // every request shows its sample in the next cycle with its own tlast
    `ASSERT_NEXT(a_one_cycle, s_axis_tvalid && s_axis_tready, m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast)))

    // a stalled output blocks new requests
    `ASSERT_SAME(a_backpressure, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind dual_tone_sine_generator_top dtsg_checker u_dtsg_checker (.*);

`default_nettype wire
